### rtl/ckfa_pkg.sv
`timescale 1ns / 1ps

package ckfa_pkg;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [3:0] HEX_TEN = 4'd10;

  typedef enum logic [2:0] {
    TR_IDLE,
    TR_STAR,
    TR_HI,
    TR_LO,
    TR_LF
  } trl_state_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] tx_byte;
    logic       frame_done;
  } trl_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
    logic [7:0] res;
    if (nibble < HEX_TEN) begin
      res = CH_ZERO + {4'd0, nibble};
    end else begin
      res = CH_A + {4'd0, nibble - HEX_TEN};
    end
    return res;
  endfunction

endpackage

### rtl/ckfa_trailer.sv
`timescale 1ns / 1ps

module ckfa_trailer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [7:0]    start_sum,
  input  logic          advance,
  output ckfa_pkg::trl_t trl
);
  import ckfa_pkg::*;

  trl_state_t state_r, state_nxt;
  logic [7:0] sum_r, sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    trl.busy       = 1'b1;
    trl.tx_byte    = CH_STAR;
    trl.frame_done = 1'b0;
    case (state_r)
      TR_IDLE: begin
        trl.busy = 1'b0;
        if (start) begin
          state_nxt = TR_STAR;
          sum_nxt   = start_sum;
        end
      end
      TR_STAR: begin
        trl.tx_byte = CH_STAR;
        if (advance) begin
          state_nxt = (sum_r >= 8'd16) ? TR_HI : TR_LO;
        end
      end
      TR_HI: begin
        trl.tx_byte = hex_digit(sum_r[7:4]);
        if (advance) begin
          state_nxt = TR_LO;
        end
      end
      TR_LO: begin
        trl.tx_byte = hex_digit(sum_r[3:0]);
        if (advance) begin
          state_nxt = TR_LF;
        end
      end
      TR_LF: begin
        trl.tx_byte    = CH_LF;
        trl.frame_done = 1'b1;
        if (advance) begin
          state_nxt = TR_IDLE;
        end
      end
      default: begin
        state_nxt = TR_IDLE;
      end
    endcase
  end

endmodule

### rtl/checksum_frame_appender_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Signals
// in_      input      in_valid, in_ready, in_payload_byte, in_final_byte
// out_     output     out_valid, out_ready, out_tx_byte, out_frame_done
//
// A payload byte is taken when it arrives and is on the output register the
// next cycle, so a frame sustains one byte per cycle unless the output stalls.
// A final byte is followed by 3 or 4 trailer bytes from the trailer sequencer,
// one per cycle unless stalled; input is held off while they go out.
// Input ready follows output ready through the output register, so a stall
// on the output stops the input in the same cycle and nothing is lost.
// Synchronous active-low reset clears the running sum and all valid state.

module checksum_frame_appender_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_frame_done
);
  import ckfa_pkg::*;

  logic [7:0] sum_r, sum_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] tx_byte_r, tx_byte_nxt;
  logic       frame_done_r, frame_done_nxt;
  logic [7:0] sum_add;
  logic       out_free;
  logic       in_xfer;
  logic       trl_adv;
  trl_t       trl;

  assign sum_add  = sum_r + in_payload_byte;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = out_free && !trl.busy;
  assign in_xfer  = in_valid && in_ready;
  assign trl_adv  = trl.busy && out_free;

  ckfa_trailer u_trailer (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer && in_final_byte),
    .start_sum (sum_add),
    .advance   (trl_adv),
    .trl       (trl)
  );

  always_comb begin
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r;
    tx_byte_nxt    = tx_byte_r;
    frame_done_nxt = frame_done_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      sum_nxt        = in_final_byte ? 8'd0 : sum_add;
      out_valid_nxt  = 1'b1;
      tx_byte_nxt    = in_payload_byte;
      frame_done_nxt = 1'b0;
    end else if (trl_adv) begin
      out_valid_nxt  = 1'b1;
      tx_byte_nxt    = trl.tx_byte;
      frame_done_nxt = trl.frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_byte_r    <= tx_byte_nxt;
    frame_done_r <= frame_done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_tx_byte    = tx_byte_r;
  assign out_frame_done = frame_done_r;

  a_final_starts_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_final_byte |=> trl.busy && (sum_r == 8'd0))
    else $error("final byte transfer did not start the trailer");

  a_sum_accumulates: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_final_byte |=> sum_r == $past(sum_add))
    else $error("running sum did not take the transferred byte");

  a_done_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_tx_byte == CH_LF)
    else $error("frame end marked on a byte other than line feed");

  a_no_input_in_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    trl.busy |-> !in_xfer)
    else $error("input transfer during trailer");

endmodule
